FILE: hdl/lacg_pkg.sv
// Shared types and constants for the layer alpha composite block.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package lacg_pkg;

    // Queue between the front end and the back end
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // Divisors of the fixed-point conversions
    localparam longint unsigned ALPHA_DIV = 64'd65025;
    localparam longint unsigned COL_DIV   = 64'd255;

    // floor(y / 65025) == (y * RECIP_M) >> RECIP_SH for every 32-bit y
    localparam logic [31:0] RECIP_M   = 32'd2164359683;
    localparam int          RECIP_SH  = 47;
    localparam logic [31:0] ALPHA_RND = 32'd32512;

    // Configuration reset values
    localparam logic [7:0] TOL_RST   = 8'd10;
    localparam logic [7:0] RED_RST   = 8'd0;
    localparam logic [7:0] GREEN_RST = 8'd0;
    localparam logic [7:0] BLUE_RST  = 8'd255;

    typedef enum logic [1:0] {
        CFG_TOLERANCE = 2'd0,
        CFG_RED       = 2'd1,
        CFG_GREEN     = 2'd2,
        CFG_BLUE      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic skip;
        logic last;
    } layer_flags_t;

    typedef struct packed {
        logic [FIFO_CW-1:0] count;
        logic               empty;
    } fifo_stat_t;

endpackage

`default_nettype wire

FILE: hdl/lacg_front.sv
// Front end: accepts layer pixels, converts colour and alpha to fixed point.
// Uses lacg_pkg; feeds lacg_fifo and throttles input on queue credit.
`default_nettype none

module lacg_front #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [7:0]                pixel_alpha,
    input  wire logic [7:0]                pixel_red,
    input  wire logic [7:0]                pixel_green,
    input  wire logic [7:0]                pixel_blue,
    input  wire logic [7:0]                layer_opacity,
    input  wire logic                      layer_skip,
    input  wire logic                      last_layer,
    input  wire lacg_pkg::fifo_stat_t      fifo_stat,
    output logic                           push,
    output logic [FRAC_BITS:0]             sa,
    output logic [FRAC_BITS:0]             s_red,
    output logic [FRAC_BITS:0]             s_green,
    output logic [FRAC_BITS:0]             s_blue,
    output lacg_pkg::layer_flags_t         flags
);

    localparam int W  = FRAC_BITS + 1;
    localparam int SW = lacg_pkg::FIFO_CW + 1;
    localparam int SH = FRAC_BITS % 8;

    localparam longint unsigned ONE_L   = 64'd1 << FRAC_BITS;
    localparam longint unsigned ALPHA_K = ONE_L / lacg_pkg::ALPHA_DIV;
    localparam longint unsigned ALPHA_R = ONE_L % lacg_pkg::ALPHA_DIV;
    localparam longint unsigned COL_E   = 64'd1 << SH;
    localparam longint unsigned COL_K   = (ONE_L - COL_E) / lacg_pkg::COL_DIV;

    localparam logic [8:0]   ALPHA_K_V = 9'(ALPHA_K);
    localparam logic [15:0]  ALPHA_R_V = 16'(ALPHA_R);
    localparam logic [W-1:0] COL_K_V   = W'(COL_K);

    // 2^F = 255*COL_K + 2^(F mod 8): split off the exact part, divide the rest
    function automatic logic [W-1:0] byte_to_fx(input logic [7:0] c);
        logic [14:0]  t;
        logic [15:0]  q;
        logic [W+7:0] base;
        t    = (15'(c) << SH) + 15'd127;
        q    = 16'(t) + 16'(t[14:8]) + 16'd1;
        base = (W+8)'(c) * (W+8)'(COL_K_V);
        return W'(base + (W+8)'(q[15:8]));
    endfunction

    logic                   accept;
    logic [SW-1:0]          in_flight;

    logic                   v1_reg;
    logic [15:0]            p1_reg;
    logic [7:0]             r1_reg;
    logic [7:0]             g1_reg;
    logic [7:0]             b1_reg;
    lacg_pkg::layer_flags_t f1_reg;

    logic                   v2_reg;
    logic [24:0]            pk2_reg;
    logic [31:0]            y2_reg;
    logic [W-1:0]           sr2_reg;
    logic [W-1:0]           sg2_reg;
    logic [W-1:0]           sb2_reg;
    lacg_pkg::layer_flags_t f2_reg;

    logic [63:0]            recip_prod;
    logic [16:0]            rem_q;
    logic [25:0]            sa_wide;

    // Hold input while queue plus pipeline would exceed the queue depth
    assign in_flight = SW'(fifo_stat.count) + SW'(v1_reg) + SW'(v2_reg);
    assign in_stall  = (in_flight >= SW'(lacg_pkg::FIFO_DEPTH));
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_reg      <= {8'd0, pixel_alpha} * {8'd0, layer_opacity};
            r1_reg      <= pixel_red;
            g1_reg      <= pixel_green;
            b1_reg      <= pixel_blue;
            f1_reg.skip <= layer_skip;
            f1_reg.last <= last_layer;
        end
        if (v1_reg)
        begin
            pk2_reg <= 25'(p1_reg) * 25'(ALPHA_K_V);
            y2_reg  <= 32'(p1_reg) * 32'(ALPHA_R_V) + lacg_pkg::ALPHA_RND;
            sr2_reg <= byte_to_fx(r1_reg);
            sg2_reg <= byte_to_fx(g1_reg);
            sb2_reg <= byte_to_fx(b1_reg);
            f2_reg  <= f1_reg;
        end
    end

    // Remainder part of the alpha division by 65025, via reciprocal multiply
    assign recip_prod = 64'(y2_reg) * 64'(lacg_pkg::RECIP_M);
    assign rem_q      = 17'(recip_prod >> lacg_pkg::RECIP_SH);
    assign sa_wide    = 26'(pk2_reg) + 26'(rem_q);

    assign push    = v2_reg;
    assign sa      = sa_wide[W-1:0];
    assign s_red   = sr2_reg;
    assign s_green = sg2_reg;
    assign s_blue  = sb2_reg;
    assign flags   = f2_reg;

endmodule

`default_nettype wire

FILE: hdl/lacg_fifo.sv
// Short queue between front end and back end, register slots with head read.
// Uses lacg_pkg for depth constants and the status struct.
`default_nettype none

module lacg_fifo #(
    parameter int DW = 70
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic [DW-1:0]        wdata,
    input  wire logic                 pop,
    output logic [DW-1:0]             rdata,
    output lacg_pkg::fifo_stat_t      stat
);

    logic [DW-1:0]                   slot_reg [lacg_pkg::FIFO_DEPTH];
    logic [lacg_pkg::FIFO_AW-1:0]    wr_ptr_reg;
    logic [lacg_pkg::FIFO_AW-1:0]    rd_ptr_reg;
    logic [lacg_pkg::FIFO_CW-1:0]    cnt_reg;
    logic [lacg_pkg::FIFO_CW-1:0]    cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata      = slot_reg[rd_ptr_reg];
    assign stat.count = cnt_reg;
    assign stat.empty = (cnt_reg == '0);

endmodule

`default_nettype wire

FILE: hdl/lacg_back.sv
// Back end: blends queued layers into the colour accumulators, finishes pixels.
// Holds the configuration registers; uses lacg_pkg.
`default_nettype none

module lacg_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [7:0]            cfg_data,
    input  wire logic                  head_valid,
    input  wire logic [FRAC_BITS:0]    head_sa,
    input  wire logic [FRAC_BITS:0]    head_s_red,
    input  wire logic [FRAC_BITS:0]    head_s_green,
    input  wire logic [FRAC_BITS:0]    head_s_blue,
    input  wire lacg_pkg::layer_flags_t head_flags,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [7:0]                 out_red,
    output logic [7:0]                 out_green,
    output logic [7:0]                 out_blue,
    output logic                       near_guide
);

    localparam int           W     = FRAC_BITS + 1;
    localparam logic [W-1:0] ONE_V = W'(1) << FRAC_BITS;

    // acc + floor(((s - acc) * sa + ONE/2) / ONE)
    function automatic logic [W-1:0] blend_ch(
        input logic [W-1:0] acc,
        input logic [W-1:0] s,
        input logic [W-1:0] alpha
    );
        logic signed [W+1:0]   diff;
        logic signed [2*W+3:0] prod;
        logic signed [2*W+3:0] shifted;
        diff    = $signed({2'b00, s}) - $signed({2'b00, acc});
        prod    = diff * $signed({2'b00, alpha});
        prod    = prod + $signed((2*W+4)'(1) << (FRAC_BITS - 1));
        shifted = prod >>> FRAC_BITS;
        return acc + shifted[W-1:0];
    endfunction

    function automatic logic [7:0] to_byte(input logic [W-1:0] acc);
        logic [W-1:0] v;
        logic [W+7:0] x;
        logic [W+7:0] y;
        v = (acc > ONE_V) ? ONE_V : acc;
        x = ((W+8)'(v) << 8) - (W+8)'(v) + ((W+8)'(1) << (FRAC_BITS - 1));
        y = x >> FRAC_BITS;
        return y[7:0];
    endfunction

    function automatic logic close_to(
        input logic [7:0] a,
        input logic [7:0] b,
        input logic [7:0] tol
    );
        logic [8:0] d;
        d = (a > b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, b} - {1'b0, a});
        return d <= {1'b0, tol};
    endfunction

    logic [7:0]   tol_reg;
    logic [7:0]   guide_r_reg;
    logic [7:0]   guide_g_reg;
    logic [7:0]   guide_b_reg;

    logic [W-1:0] acc_r_reg;
    logic [W-1:0] acc_g_reg;
    logic [W-1:0] acc_b_reg;
    logic [W-1:0] acc_r_next;
    logic [W-1:0] acc_g_next;
    logic [W-1:0] acc_b_next;

    logic         fin_valid_reg;
    logic [W-1:0] fin_r_reg;
    logic [W-1:0] fin_g_reg;
    logic [W-1:0] fin_b_reg;

    logic         out_valid_reg;
    logic [7:0]   out_r_reg;
    logic [7:0]   out_g_reg;
    logic [7:0]   out_b_reg;
    logic         near_reg;

    logic         out_free;
    logic         fin_free;
    logic         fin_move;
    logic [7:0]   byte_r;
    logic [7:0]   byte_g;
    logic [7:0]   byte_b;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg     <= lacg_pkg::TOL_RST;
            guide_r_reg <= lacg_pkg::RED_RST;
            guide_g_reg <= lacg_pkg::GREEN_RST;
            guide_b_reg <= lacg_pkg::BLUE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lacg_pkg::CFG_TOLERANCE: tol_reg     <= cfg_data;
                lacg_pkg::CFG_RED:       guide_r_reg <= cfg_data;
                lacg_pkg::CFG_GREEN:     guide_g_reg <= cfg_data;
                lacg_pkg::CFG_BLUE:      guide_b_reg <= cfg_data;
                default:                 tol_reg     <= tol_reg;
            endcase
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign fin_free = !fin_valid_reg || out_free;
    assign fin_move = fin_valid_reg && out_free;

    // Non-last layers never need the finish stage, so they always drain
    assign pop = head_valid && (fin_free || !head_flags.last);

    always_comb
    begin
        acc_r_next = acc_r_reg;
        acc_g_next = acc_g_reg;
        acc_b_next = acc_b_reg;
        if (!head_flags.skip)
        begin
            acc_r_next = blend_ch(acc_r_reg, head_s_red, head_sa);
            acc_g_next = blend_ch(acc_g_reg, head_s_green, head_sa);
            acc_b_next = blend_ch(acc_b_reg, head_s_blue, head_sa);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_r_reg     <= ONE_V;
            acc_g_reg     <= ONE_V;
            acc_b_reg     <= ONE_V;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (head_flags.last)
                begin
                    // back to white for the next screen pixel
                    acc_r_reg <= ONE_V;
                    acc_g_reg <= ONE_V;
                    acc_b_reg <= ONE_V;
                end
                else
                begin
                    acc_r_reg <= acc_r_next;
                    acc_g_reg <= acc_g_next;
                    acc_b_reg <= acc_b_next;
                end
            end

            if (pop && head_flags.last)
            begin
                fin_valid_reg <= 1'b1;
            end
            else if (fin_move)
            begin
                fin_valid_reg <= 1'b0;
            end

            if (fin_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign byte_r = to_byte(fin_r_reg);
    assign byte_g = to_byte(fin_g_reg);
    assign byte_b = to_byte(fin_b_reg);

    always_ff @(posedge clk)
    begin
        if (pop && head_flags.last)
        begin
            fin_r_reg <= acc_r_next;
            fin_g_reg <= acc_g_next;
            fin_b_reg <= acc_b_next;
        end
        if (fin_move)
        begin
            out_r_reg <= byte_r;
            out_g_reg <= byte_g;
            out_b_reg <= byte_b;
            near_reg  <= close_to(byte_r, guide_r_reg, tol_reg)
                      && close_to(byte_g, guide_g_reg, tol_reg)
                      && close_to(byte_b, guide_b_reg, tol_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_red    = out_r_reg;
    assign out_green  = out_g_reg;
    assign out_blue   = out_b_reg;
    assign near_guide = near_reg;

endmodule

`default_nettype wire

FILE: hdl/layer_alpha_composite_guide_unit.sv
// Layer alpha composite with guide-colour check: top level.
// Instantiates lacg_front, lacg_fifo and lacg_back; uses lacg_pkg.
//
// Usage:
//   Feed one layer pixel per transaction on the input channel (in_valid /
//   in_stall), bottom layer first, last_layer set on the topmost one. Each
//   screen pixel starts from white. After the last layer one transaction
//   leaves on the output channel (out_valid / out_stall) with the clamped,
//   rounded colour and near_guide.
//   Guide colour and tolerance sit behind the cfg port (cfg_valid, cfg_ready,
//   cfg_index, cfg_data); cfg_ready is always high. Write them only while idle.
// Timing:
//   Throughput is one layer pixel per cycle while in_stall is low, set by
//   the per-channel blend multiply-add that closes on the accumulator
//   registers in the back end. From accepting the last layer to out_valid,
//   a result passes the two front-end stages, the queue, the blend into the
//   finish stage and the output byte conversion stage.
//   in_stall rises when the queue plus the front-end stages hold four items.
//   While out_stall holds a result, the next result waits in the finish
//   stage; after that the queue fills and in_stall rises.
// Reset:
//   rst_n clears all transactions in flight, sets the accumulators to white
//   and the configuration to tolerance 10, guide colour pure blue.
`default_nettype none

module layer_alpha_composite_guide_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  pixel_alpha,
    input  wire logic [7:0]  pixel_red,
    input  wire logic [7:0]  pixel_green,
    input  wire logic [7:0]  pixel_blue,
    input  wire logic [7:0]  layer_opacity,
    input  wire logic        layer_skip,
    input  wire logic        last_layer,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_red,
    output logic [7:0]       out_green,
    output logic [7:0]       out_blue,
    output logic             near_guide,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam int W  = FRAC_BITS + 1;
    localparam int EW = 4 * W + 2;

    lacg_pkg::fifo_stat_t   fifo_stat;
    lacg_pkg::layer_flags_t front_flags;
    lacg_pkg::layer_flags_t head_flags;

    logic           push;
    logic           pop;
    logic [W-1:0]   front_sa;
    logic [W-1:0]   front_s_r;
    logic [W-1:0]   front_s_g;
    logic [W-1:0]   front_s_b;
    logic [W-1:0]   head_sa;
    logic [W-1:0]   head_s_r;
    logic [W-1:0]   head_s_g;
    logic [W-1:0]   head_s_b;
    logic [EW-1:0]  wdata;
    logic [EW-1:0]  rdata;

    lacg_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel_alpha   (pixel_alpha),
        .pixel_red     (pixel_red),
        .pixel_green   (pixel_green),
        .pixel_blue    (pixel_blue),
        .layer_opacity (layer_opacity),
        .layer_skip    (layer_skip),
        .last_layer    (last_layer),
        .fifo_stat     (fifo_stat),
        .push          (push),
        .sa            (front_sa),
        .s_red         (front_s_r),
        .s_green       (front_s_g),
        .s_blue        (front_s_b),
        .flags         (front_flags)
    );

    assign wdata = {front_sa, front_s_r, front_s_g, front_s_b, front_flags};

    lacg_fifo #(
        .DW (EW)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wdata),
        .pop   (pop),
        .rdata (rdata),
        .stat  (fifo_stat)
    );

    assign {head_sa, head_s_r, head_s_g, head_s_b, head_flags} = rdata;

    lacg_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .head_valid   (!fifo_stat.empty),
        .head_sa      (head_sa),
        .head_s_red   (head_s_r),
        .head_s_green (head_s_g),
        .head_s_blue  (head_s_b),
        .head_flags   (head_flags),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .near_guide   (near_guide)
    );

endmodule

`default_nettype wire

FILE: hdl/lacg_checker.sv
// Port-level checks for the layer alpha composite top level, bound to it.
// Shadows the configuration writes; uses lacg_pkg for reset values.
`default_nettype none

module lacg_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       cfg_valid,
    input wire logic       cfg_ready,
    input wire logic [1:0] cfg_index,
    input wire logic [7:0] cfg_data,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_red,
    input wire logic [7:0] out_green,
    input wire logic [7:0] out_blue,
    input wire logic       near_guide
);

    logic [7:0] tol_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [8:0] d_red;
    logic [8:0] d_green;
    logic [8:0] d_blue;
    logic       near_exp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= lacg_pkg::TOL_RST;
            red_reg   <= lacg_pkg::RED_RST;
            green_reg <= lacg_pkg::GREEN_RST;
            blue_reg  <= lacg_pkg::BLUE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lacg_pkg::CFG_TOLERANCE: tol_reg   <= cfg_data;
                lacg_pkg::CFG_RED:       red_reg   <= cfg_data;
                lacg_pkg::CFG_GREEN:     green_reg <= cfg_data;
                lacg_pkg::CFG_BLUE:      blue_reg  <= cfg_data;
                default:                 tol_reg   <= tol_reg;
            endcase
        end
    end

    always_comb
    begin
        d_red   = (out_red > red_reg) ? ({1'b0, out_red} - {1'b0, red_reg})
                                      : ({1'b0, red_reg} - {1'b0, out_red});
        d_green = (out_green > green_reg) ? ({1'b0, out_green} - {1'b0, green_reg})
                                          : ({1'b0, green_reg} - {1'b0, out_green});
        d_blue  = (out_blue > blue_reg) ? ({1'b0, out_blue} - {1'b0, blue_reg})
                                        : ({1'b0, blue_reg} - {1'b0, out_blue});
        near_exp = (d_red <= {1'b0, tol_reg}) && (d_green <= {1'b0, tol_reg})
                && (d_blue <= {1'b0, tol_reg});
    end

    // near_guide must agree with the colour shown and the last written guide
    a_near_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (near_guide == near_exp))
        else $error("near_guide disagrees with colour and guide settings");

    // no result can be pending right after reset release
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result visible right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_red)
            && $stable(out_green) && $stable(out_blue) && $stable(near_guide)))
        else $error("stalled result changed or dropped");

endmodule

bind layer_alpha_composite_guide_unit lacg_checker u_lacg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .near_guide (near_guide)
);

`default_nettype wire

FILE: tb/sv/layer_alpha_composite_guide_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for layer_alpha_composite_guide_unit: layer stacks in,
// composited pixels out, each checked against a fixed-point blend predictor.
// Depends on lacg_pkg for the register index enum.

module layer_alpha_composite_guide_unit_tb;

    localparam int FRAC = 16;
    localparam longint unsigned FX_ONE = 64'd1 << FRAC;
    localparam int MAX_WAIT = 6;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES = 10;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_PRINTED = 40;

    typedef struct {
        bit [7:0] a;
        bit [7:0] r;
        bit [7:0] g;
        bit [7:0] b;
        bit [7:0] op;
        bit       skip;
        bit       last;
    } layer_px_t;

    typedef struct {
        bit [7:0] r;
        bit [7:0] g;
        bit [7:0] b;
        bit       near;
    } screen_px_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] pixel_alpha;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] layer_opacity;
    logic       layer_skip;
    logic       last_layer;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       near_guide;
    logic       cfg_valid;
    logic       cfg_ready;
    lacg_pkg::cfg_reg_t cfg_index;
    logic [7:0] cfg_data;

    // Predictor state: running colour sums and the guide settings
    bit [FRAC:0] sum_r = (FRAC + 1)'(FX_ONE);
    bit [FRAC:0] sum_g = (FRAC + 1)'(FX_ONE);
    bit [FRAC:0] sum_b = (FRAC + 1)'(FX_ONE);
    bit [7:0]    tol_q = 8'd10;
    bit [7:0]    key_r = 8'd0;
    bit [7:0]    key_g = 8'd0;
    bit [7:0]    key_b = 8'd255;

    screen_px_t expected_pixels[$];

    bit sender_idle = 1'b1;
    bit receiver_idle = 1'b1;
    bit hold_pending = 1'b0;

    int mismatches = 0;
    int layers_sent = 0;
    int results_checked = 0;
    int cfg_writes = 0;
    int idle_cycles = 0;
    int in_stall_cycles = 0;

    layer_alpha_composite_guide_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel_alpha   (pixel_alpha),
        .pixel_red     (pixel_red),
        .pixel_green   (pixel_green),
        .pixel_blue    (pixel_blue),
        .layer_opacity (layer_opacity),
        .layer_skip    (layer_skip),
        .last_layer    (last_layer),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_red       (out_red),
        .out_green     (out_green),
        .out_blue      (out_blue),
        .near_guide    (near_guide),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic bit [FRAC:0] to_fixed(bit [7:0] c);
        longint unsigned w;
        w = c;
        return (FRAC + 1)'((w * FX_ONE + 64'd127) / 64'd255);
    endfunction

    function automatic bit [FRAC:0] mix_channel(bit [FRAC:0] acc, bit [FRAC:0] s,
                                                bit [FRAC:0] sa);
        longint unsigned acc_w;
        longint unsigned s_w;
        longint unsigned sa_w;
        acc_w = acc;
        s_w = s;
        sa_w = sa;
        return (FRAC + 1)'((s_w * sa_w + acc_w * (FX_ONE - sa_w) + FX_ONE / 2) >> FRAC);
    endfunction

    function automatic bit [7:0] to_byte(bit [FRAC:0] acc);
        longint unsigned v;
        v = (acc > FX_ONE) ? FX_ONE : acc;
        return 8'((v * 64'd255 + FX_ONE / 2) >> FRAC);
    endfunction

    function automatic bit close_to(bit [7:0] x, bit [7:0] y, bit [7:0] tol);
        bit [7:0] d;
        d = (x > y) ? x - y : y - x;
        return d <= tol;
    endfunction

    // Blend one accepted layer into the sums unless it is skipped; queue the pixel on the top layer
    function automatic void absorb_layer(layer_px_t px);
        bit [FRAC:0]     sa;
        longint unsigned a_w;
        longint unsigned op_w;
        screen_px_t      res;
        if (!px.skip)
        begin
            a_w = px.a;
            op_w = px.op;
            sa = (FRAC + 1)'((a_w * op_w * FX_ONE + 64'd32512) / 64'd65025);
            sum_r = mix_channel(sum_r, to_fixed(px.r), sa);
            sum_g = mix_channel(sum_g, to_fixed(px.g), sa);
            sum_b = mix_channel(sum_b, to_fixed(px.b), sa);
        end
        if (px.last)
        begin
            res.r = to_byte(sum_r);
            res.g = to_byte(sum_g);
            res.b = to_byte(sum_b);
            res.near = close_to(res.r, key_r, tol_q) && close_to(res.g, key_g, tol_q) &&
                       close_to(res.b, key_b, tol_q);
            expected_pixels.push_back(res);
            sum_r = (FRAC + 1)'(FX_ONE);
            sum_g = (FRAC + 1)'(FX_ONE);
            sum_b = (FRAC + 1)'(FX_ONE);
        end
    endfunction

    function automatic layer_px_t make_layer(bit [7:0] a, bit [7:0] r, bit [7:0] g,
                                             bit [7:0] b, bit [7:0] op, bit skip,
                                             bit last);
        layer_px_t px;
        px.a = a;
        px.r = r;
        px.g = g;
        px.b = b;
        px.op = op;
        px.skip = skip;
        px.last = last;
        return px;
    endfunction

    // Favor the ends of the byte range
    function automatic bit [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic layer_px_t random_layer(bit last);
        return make_layer(pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                          $urandom_range(0, 5) == 0, last);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] MISMATCH result %0d %s: got %0d expected %0d",
                     $realtime, results_checked, what, got, want);
    endtask

    task automatic send_layer(layer_px_t px);
        int unsigned gap;
        gap = sender_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_alpha <= px.a;
        pixel_red <= px.r;
        pixel_green <= px.g;
        pixel_blue <= px.b;
        layer_opacity <= px.op;
        layer_skip <= px.skip;
        last_layer <= px.last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        absorb_layer(px);
        layers_sent++;
    endtask

    task automatic send_stack(int depth);
        for (int i = 0; i < depth; i++)
            send_layer(random_layer(i == depth - 1));
    endtask

    // Drop valid, drain every expected pixel, then cover the pipeline latency
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(lacg_pkg::cfg_reg_t idx, bit [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            lacg_pkg::CFG_TOLERANCE: tol_q = value;
            lacg_pkg::CFG_RED:       key_r = value;
            lacg_pkg::CFG_GREEN:     key_g = value;
            lacg_pkg::CFG_BLUE:      key_b = value;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_guide(bit [7:0] tol, bit [7:0] r, bit [7:0] g, bit [7:0] b);
        settle();
        write_reg(lacg_pkg::CFG_TOLERANCE, tol);
        write_reg(lacg_pkg::CFG_RED, r);
        write_reg(lacg_pkg::CFG_GREEN, g);
        write_reg(lacg_pkg::CFG_BLUE, b);
        cfg_valid <= 1'b0;
    endtask

    // Guide is pure blue with tolerance 10 out of reset
    task automatic test_reset_state();
        send_layer(make_layer(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1));
        send_layer(make_layer(8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0, 1'b1));
        settle();
    endtask

    task automatic test_field_extremes();
        send_layer(make_layer(8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0, 1'b1));
        send_layer(make_layer(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1));
        // zero pixel alpha on top leaves the red below untouched
        send_layer(make_layer(8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 1'b0, 1'b0));
        send_layer(make_layer(8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 1'b0, 1'b1));
        send_layer(make_layer(8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 1'b0, 1'b1));
        send_layer(make_layer(8'd1, 8'd0, 8'd0, 8'd0, 8'd1, 1'b0, 1'b1));
        // skipped layers carry full-scale junk; a skipped top still emits
        send_layer(make_layer(8'd128, 8'd255, 8'd0, 8'd0, 8'd200, 1'b0, 1'b0));
        send_layer(make_layer(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0));
        send_layer(make_layer(8'd200, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1, 1'b1));
        settle();
    endtask

    task automatic test_guide_registers();
        set_guide(8'd0, 8'd255, 8'd255, 8'd255);
        send_layer(make_layer(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1));
        send_layer(make_layer(8'd255, 8'd254, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1));
        set_guide(8'd255, 8'd0, 8'd0, 8'd0);
        send_layer(random_layer(1'b1));
        set_guide(8'd0, 8'd0, 8'd0, 8'd0);
        send_layer(make_layer(8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0, 1'b1));
        // right at the tolerance edge, then one step past it
        set_guide(8'd3, 8'd128, 8'd64, 8'd200);
        send_layer(make_layer(8'd255, 8'd131, 8'd61, 8'd200, 8'd255, 1'b0, 1'b1));
        send_layer(make_layer(8'd255, 8'd132, 8'd64, 8'd200, 8'd255, 1'b0, 1'b1));
        settle();
    endtask

    // Receiver holds off while the sender streams, so the block backs up
    task automatic test_output_hold_off();
        sender_idle = 1'b0;
        receiver_idle = 1'b0;
        hold_pending = 1'b1;
        for (int i = 0; i < 30; i++)
            send_stack($urandom_range(1, 2));
        settle();
    endtask

    task automatic test_random_stacks();
        int sent;
        int depth;
        bit [7:0] tol;
        for (int batch = 0; batch < 10; batch++)
        begin
            case ($urandom_range(0, 3))
                0: tol = 8'd0;
                1: tol = 8'd255;
                2: tol = 8'($urandom_range(0, 16));
                default: tol = 8'($urandom_range(0, 255));
            endcase
            set_guide(tol, pick_byte(), pick_byte(), pick_byte());
            if (batch % 4 == 0)
            begin
                sender_idle = 1'b0;
                receiver_idle = 1'b0;
            end
            else
            begin
                sender_idle = 1'($urandom_range(0, 1));
                receiver_idle = 1'($urandom_range(0, 1));
            end
            sent = 0;
            while (sent < 150)
            begin
                depth = $urandom_range(1, 6);
                send_stack(depth);
                sent += depth;
            end
        end
        settle();
    endtask

    initial
    begin : receiver
        int unsigned n;
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                n = HOLD_OFF_CYCLES;
            end
            else
                n = receiver_idle ? $urandom_range(0, MAX_WAIT) : 0;
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_results
        screen_px_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("unexpected transaction, out_red", out_red, -1);
            else
            begin
                want = expected_pixels.pop_front();
                if (out_red !== want.r)
                    report_mismatch("out_red", out_red, want.r);
                if (out_green !== want.g)
                    report_mismatch("out_green", out_green, want.g);
                if (out_blue !== want.b)
                    report_mismatch("out_blue", out_blue, want.b);
                if (near_guide !== want.near)
                    report_mismatch("near_guide", near_guide, want.near);
            end
            results_checked++;
        end
    end

    always @(posedge clk)
    begin
        if (in_valid && in_stall)
            in_stall_cycles <= in_stall_cycles + 1;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[%0t] watchdog: no transaction for %0d cycles, %0d pixels pending",
                     $realtime, idle_cycles, expected_pixels.size());
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        pixel_alpha <= 8'd0;
        pixel_red <= 8'd0;
        pixel_green <= 8'd0;
        pixel_blue <= 8'd0;
        layer_opacity <= 8'd0;
        layer_skip <= 1'b0;
        last_layer <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= lacg_pkg::CFG_TOLERANCE;
        cfg_data <= 8'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_state();
        test_field_extremes();
        test_guide_registers();
        test_output_hold_off();
        test_random_stacks();

        $display("Run covered %0d layer pixels, %0d composited pixels, %0d register writes",
                 layers_sent, results_checked, cfg_writes);
        $display("Input stalled for %0d cycles under output back-pressure; %0d mismatches",
                 in_stall_cycles, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
